@@ rtl/x86_insn_length_decoder_unit_macros.svh @@
// Assertion helpers
`ifndef X86_INSN_LENGTH_DECODER_UNIT_MACROS_SVH
`define X86_INSN_LENGTH_DECODER_UNIT_MACROS_SVH
`define XILD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define XILD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/xild_pkg.sv @@
package xild_pkg;

  localparam int unsigned WindowBytes = 16;

  typedef struct packed {
    logic [63:0] window_high;
    logic [63:0] window_low;
    logic [4:0]  bytes_available;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]         insn_length;
    logic               too_long;
    logic               syscall_flag;
    logic               direct_jump_flag;
    logic               call_flag;
    logic               indirect_branch_flag;
    logic               return_flag;
    logic               nop_flag;
    logic signed [31:0] rel_offset;
  } out_beat_t;

  typedef enum logic [3:0] {
    IcNone, IcB, IcW, IcZ, IcV, IcMoffs, IcEnter, IcGrp3, IcRel, IcPush, IcFar
  } imm_cls_e;

  localparam logic [7:0] OpEsc  = 8'h0F;
  localparam logic [7:0] OpVex2 = 8'hC5;
  localparam logic [7:0] OpVex3 = 8'hC4;
  localparam logic [7:0] OpEvex = 8'h62;
  localparam logic [7:0] OpOsz  = 8'h66;
  localparam logic [7:0] OpAsz  = 8'h67;

  localparam logic [15:0] ModrmRows [16] = '{
    16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0000, 16'h0000, 16'h0A0C, 16'h0000,
    16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h00C3, 16'hFF0F, 16'h0000, 16'hC0C0
  };

  function automatic logic has_modrm1(logic [7:0] op);
    logic [15:0] row;
    row = ModrmRows[op[7:4]];
    return row[op[3:0]];
  endfunction

  function automatic imm_cls_e imm_class1(logic [7:0] op);
    imm_cls_e c;
    c = IcNone;
    if (op < 8'h40) begin
      if (op[2:0] == 3'd4) c = IcB;
      else if (op[2:0] == 3'd5) c = IcZ;
    end else if (op inside {[8'h70:8'h7F], [8'hB0:8'hB7], [8'hE0:8'hE7]}) c = IcB;
    else if (op inside {[8'hB8:8'hBF]}) c = IcV;
    else if (op inside {[8'hA0:8'hA3]}) c = IcMoffs;
    else if (op == 8'h68) c = IcPush;
    else if (op inside {8'h69, 8'h81, 8'hA9, 8'hC7}) c = IcZ;
    else if (op inside {8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1,
                        8'hC6, 8'hCD, 8'hD4, 8'hD5, 8'hEB}) c = IcB;
    else if (op inside {8'hC2, 8'hCA}) c = IcW;
    else if (op == 8'hC8) c = IcEnter;
    else if (op inside {8'hE8, 8'hE9}) c = IcRel;
    else if (op inside {8'hF6, 8'hF7}) c = IcGrp3;
    else if (op inside {8'h9A, 8'hEA}) c = IcFar;
    return c;
  endfunction

  function automatic logic has_modrm2(logic [7:0] op);
    logic r;
    r = 1'b1;
    if (op inside {[8'h80:8'h8F], [8'hC8:8'hCF], 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
                   8'h0B, 8'h0E, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h37,
                   8'h77, 8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9, 8'hAA}) r = 1'b0;
    return r;
  endfunction

  function automatic imm_cls_e imm_class2(logic [7:0] op);
    imm_cls_e c;
    c = IcNone;
    if (op inside {[8'h80:8'h8F]}) c = IcRel;
    else if (op inside {8'h70, 8'h71, 8'h72, 8'h73, 8'hA4, 8'hAC, 8'hBA, 8'hC2,
                        8'hC4, 8'hC5, 8'hC6, 8'h0F}) c = IcB;
    return c;
  endfunction

  function automatic logic [3:0] imm_size(imm_cls_e c, logic o16, logic w, logic lm,
                                          logic a16);
    logic [3:0] s;
    case (c)
      IcB:     s = 4'd1;
      IcW:     s = 4'd2;
      IcZ:     s = (o16 && !w) ? 4'd2 : 4'd4;
      IcPush:  s = o16 ? 4'd2 : 4'd4;
      IcV:     s = w ? 4'd8 : (o16 ? 4'd2 : 4'd4);
      IcEnter: s = 4'd3;
      IcRel:   s = (o16 && !lm) ? 4'd2 : 4'd4;
      IcMoffs: s = lm ? (a16 ? 4'd4 : 4'd8) : (a16 ? 4'd2 : 4'd4);
      IcFar:   s = lm ? 4'd0 : (o16 ? 4'd4 : 4'd6);
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/xild_addr.sv @@
module xild_addr (
  input  logic [7:0] modrm_i,
  input  logic [7:0] sib_i,
  input  logic       modrm_ok_i,
  input  logic       sib_ok_i,
  input  logic       a16_i,
  output logic [2:0] len_o
);
  logic [1:0] md;
  logic [2:0] rm;
  assign md = modrm_i[7:6];
  assign rm = modrm_i[2:0];

  always_comb begin
    len_o = 3'd1;
    if (modrm_ok_i && md != 2'd3) begin
      if (a16_i) begin
        if (md == 2'd0 && rm == 3'd6) len_o = 3'd3;
        else if (md == 2'd1) len_o = 3'd2;
        else if (md == 2'd2) len_o = 3'd3;
      end else begin
        if (rm == 3'd4) begin
          len_o = 3'd2;
          if (md == 2'd0 && sib_ok_i && sib_i[2:0] == 3'd5) len_o = 3'd6;
        end else if (md == 2'd0 && rm == 3'd5) begin
          len_o = 3'd5;
        end
        if (md == 2'd1) len_o = len_o + 3'd1;
        else if (md == 2'd2) len_o = len_o + 3'd4;
      end
    end
  end
endmodule

@@ rtl/xild_core.sv @@
module xild_core (
  input  xild_pkg::in_beat_t  in_i,
  input  logic                lm_i,
  output xild_pkg::out_beat_t out_o
);
  logic [7:0] b [16];
  logic [4:0] n;
  logic [3:0] np;
  logic       o16, a16, a16m;
  logic       stop;
  logic [3:0] pp;
  logic [7:0] x;
  logic       isvex;
  logic [7:0] vlead, vop, vop1;
  logic [4:0] vmap;
  logic [5:0] pv;
  logic       rex, w;
  logic [4:0] po;
  logic [7:0] op, op2;
  logic [5:0] pm1, pm2, pm3;
  logic [2:0] al1, al2, al3;
  logic [5:0] p, q;
  logic [2:0] reg3;
  logic       regok;
  xild_pkg::imm_cls_e cls;
  logic [3:0] il;
  logic [31:0] imm32;
  xild_pkg::out_beat_t r;

  function automatic logic [7:0] byt(logic [7:0] bb [16], logic [5:0] i);
    return bb[i[3:0]];
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i]   = in_i.window_low[8*i +: 8];
      b[i+8] = in_i.window_high[8*i +: 8];
    end
    n = (in_i.bytes_available > 5'(xild_pkg::WindowBytes)) ?
        5'(xild_pkg::WindowBytes) : in_i.bytes_available;
  end

  // prefix scan: at most 16 independent compares with a first-miss pick
  always_comb begin
    o16 = 1'b0;
    a16 = 1'b0;
    stop = 1'b0;
    pp = 4'd0;
    np = 4'd0;
    for (int i = 0; i < 16; i++) begin
      x = b[i];
      if (!stop) begin
        if (5'(i) >= n) begin
          stop = 1'b1;
        end else if (x == xild_pkg::OpOsz) begin
          o16 = 1'b1;
        end else if (x == xild_pkg::OpAsz) begin
          a16 = 1'b1;
        end else if (!(x inside {8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26,
                                 8'h64, 8'h65})) begin
          stop = 1'b1;
        end
        if (!stop) np = np + 4'd1;
      end
    end
    pp = np;
  end

  logic [4:0] p0;
  assign p0 = (!stop && n == 5'd16) ? 5'd16 : {1'b0, pp};
  assign a16m = !lm_i && a16;

  always_comb begin
    vlead = byt(b, {1'b0, p0});
    isvex = (p0 < n) && (vlead == xild_pkg::OpVex2 || vlead == xild_pkg::OpVex3 ||
             (lm_i && vlead == xild_pkg::OpEvex));
    vmap = 5'd1;
    vop1 = byt(b, 6'(p0) + 6'd1);
    if (vlead == xild_pkg::OpVex3) begin
      if (6'(p0) + 6'd1 < 6'(n)) vmap = vop1[4:0];
      pv = 6'(p0) + 6'd3;
    end else if (vlead == xild_pkg::OpEvex) begin
      if (6'(p0) + 6'd1 < 6'(n)) vmap = {2'b0, vop1[2:0]};
      pv = 6'(p0) + 6'd4;
    end else begin
      pv = 6'(p0) + 6'd2;
    end
    vop = byt(b, pv);
    rex = lm_i && (p0 < n) && vlead[7:4] == 4'h4;
    w = rex && vlead[3];
    po = rex ? p0 + 5'd1 : p0;
    op = byt(b, 6'(po));
    op2 = byt(b, 6'(po) + 6'd1);
  end

  assign pm1 = pv + 6'd1;
  assign pm2 = 6'(po) + 6'd2 + ((op2 == 8'h38 || op2 == 8'h3A) &&
               (6'(po) + 6'd2 < 6'(n)) ? 6'd1 : 6'd0);
  assign pm3 = 6'(po) + 6'd1;

  xild_addr u_a1 (.modrm_i(byt(b, pm1)), .sib_i(byt(b, pm1 + 6'd1)),
    .modrm_ok_i(pm1 < 6'(n)), .sib_ok_i(pm1 + 6'd1 < 6'(n)), .a16_i(a16m), .len_o(al1));
  xild_addr u_a2 (.modrm_i(byt(b, pm2)), .sib_i(byt(b, pm2 + 6'd1)),
    .modrm_ok_i(pm2 < 6'(n)), .sib_ok_i(pm2 + 6'd1 < 6'(n)), .a16_i(a16m), .len_o(al2));
  xild_addr u_a3 (.modrm_i(byt(b, pm3)), .sib_i(byt(b, pm3 + 6'd1)),
    .modrm_ok_i(pm3 < 6'(n)), .sib_ok_i(pm3 + 6'd1 < 6'(n)), .a16_i(a16m), .len_o(al3));

  always_comb begin
    r = '0;
    r.rel_offset = '0;
    p = 6'd1;
    q = '0;
    reg3 = '0;
    regok = 1'b0;
    cls = xild_pkg::IcNone;
    il = '0;
    imm32 = '0;
    if (n == 5'd0) begin
      p = 6'd1;
    end else if (isvex) begin
      p = pv;
      if (pv < 6'(n)) begin
        p = pv + 6'd1;
        if (!(vmap == 5'd1 && vop == 8'h77)) p = p + 6'(al1);
        if (vmap == 5'd3 || (vmap == 5'd1 && (vop inside {[8'h70:8'h73], 8'hC2, 8'hC4,
            8'hC5, 8'hC6}))) p = p + 6'd1;
      end
    end else if (5'(po) >= n) begin
      p = (po == 5'd0) ? 6'd1 : 6'(po);
    end else if (op == xild_pkg::OpEsc) begin
      if (6'(po) + 6'd1 >= 6'(n)) begin
        p = 6'(po) + 6'd1;
      end else if (op2 == 8'h38 || op2 == 8'h3A) begin
        p = pm2 + 6'(al2);
        if (op2 == 8'h3A && p < 6'(n)) p = p + 6'd1;
      end else begin
        r.syscall_flag = (op2 == 8'h05 || op2 == 8'h34);
        r.nop_flag = (op2 == 8'h1F);
        p = 6'(po) + 6'd2;
        if (xild_pkg::has_modrm2(op2)) p = p + 6'(al2);
        p = p + 6'(xild_pkg::imm_size(xild_pkg::imm_class2(op2), o16, w, lm_i, a16));
      end
    end else begin
      r.nop_flag = (op == 8'h90);
      r.return_flag = (op inside {8'hC3, 8'hCB, 8'hC2, 8'hCA});
      p = pm3;
      if (xild_pkg::has_modrm1(op)) begin
        regok = pm3 < 6'(n);
        reg3 = op2[5:3];
        if (op == 8'hFF && regok && (reg3 == 3'd2 || reg3 == 3'd4)) begin
          r.indirect_branch_flag = 1'b1;
          r.call_flag = (reg3 == 3'd2);
        end
        p = p + 6'(al3);
      end
      cls = xild_pkg::imm_class1(op);
      if (cls == xild_pkg::IcGrp3)
        cls = (regok && (reg3 == 3'd0 || reg3 == 3'd1)) ?
              ((op == 8'hF6) ? xild_pkg::IcB : xild_pkg::IcZ) : xild_pkg::IcNone;
      il = xild_pkg::imm_size(cls, o16, w, lm_i, a16);
      imm32 = {byt(b, p + 6'd3), byt(b, p + 6'd2), byt(b, p + 6'd1), byt(b, p)};
      q = p + 6'(il);
      if ((op == 8'hE9 || op == 8'hE8) && q <= 6'(n)) begin
        if (il >= 4'd4) r.rel_offset = imm32;
        else r.rel_offset = {{16{imm32[15]}}, imm32[15:0]};
        if (op == 8'hE9) r.direct_jump_flag = 1'b1;
        else r.call_flag = 1'b1;
      end else if (op == 8'hEB && p < 6'(n)) begin
        r.rel_offset = {{24{imm32[7]}}, imm32[7:0]};
        r.direct_jump_flag = 1'b1;
      end else if (op == 8'hCD && p < 6'(n) && imm32[7:0] == 8'h80) begin
        r.syscall_flag = 1'b1;
      end
      p = q;
    end
    r.insn_length = (p > 6'd16) ? 5'd16 : p[4:0];
    r.too_long = p > 6'd15;
    out_o = r;
  end
endmodule

@@ rtl/x86_insn_length_decoder_unit.sv @@
// channel | dir | handshake        | payload
// in      | in  | in_valid/stall   | in_data_i (window, bytes_available)
// out     | out | out_valid/stall  | out_data_o (length, flags, offset)
// One beat per cycle unless the output stalls; a taken beat is decoded from in_q.
// Input register and result register sit around one decode stage.
// Reset clears valids and sets long_mode to 1.
// A stall holds the result and any full input stage; a free slot takes new input.
`include "x86_insn_length_decoder_unit_macros.svh"
module x86_insn_length_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xild_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xild_pkg::out_beat_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic               lm_q;
  logic               iv_q, ov_q;
  xild_pkg::in_beat_t  in_q;
  xild_pkg::out_beat_t res_d, res_q;
  logic               adv_o, adv_i;

  assign pready = 1'b1;
  assign prdata = {31'b0, lm_q};

  assign adv_o = !ov_q || !out_stall_i;
  assign adv_i = !iv_q || adv_o;
  assign in_stall_o = !adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lm_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      lm_q <= pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (adv_i) iv_q <= in_valid_i;
      if (adv_o) ov_q <= iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_i) in_q <= in_data_i;
    if (adv_o && iv_q) res_q <= res_d;
  end

  xild_core u_core (.in_i(in_q), .lm_i(lm_q), .out_o(res_d));

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  `XILD_ASSERT_NXT(a_hold, ov_q && out_stall_i, ov_q)
  `XILD_ASSERT_IMP(a_len, ov_q, res_q.insn_length != 5'd0)
  `XILD_ASSERT_IMP(a_tl, ov_q && res_q.too_long, res_q.insn_length == 5'd16)
endmodule

@@ verif/x86_insn_length_decoder_unit_tb.sv @@
`timescale 1ns / 100ps
module x86_insn_length_decoder_unit_tb;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  xild_pkg::in_beat_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  xild_pkg::out_beat_t out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [0:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  localparam logic [0:0] AddrLongMode = 1'b0;
  localparam int CycleLimit = 400000;

  typedef struct {
    xild_pkg::in_beat_t  ib;
    bit                  lm;
    bit                  fixed;
    xild_pkg::out_beat_t fx;
  } window_row_t;

  xild_pkg::out_beat_t decoded_q[$];
  window_row_t         windows[$];
  int                  mismatches;
  int                  cycles;
  int                  snd_idle;
  int                  rcv_idle;
  bit                  mode_r;

  x86_insn_length_decoder_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [15:0] modrm_row(logic [3:0] hi);
    case (hi)
      4'h0, 4'h1, 4'h2, 4'h3: return 16'h0F0F;
      4'h6: return 16'h0A0C;
      4'h8: return 16'hFFFF;
      4'hC: return 16'h00C3;
      4'hD: return 16'hFF0F;
      4'hF: return 16'hC0C0;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic bit is_legacy(logic [7:0] x);
    case (x)
      8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic xild_pkg::imm_cls_e op1_imm(logic [7:0] op);
    if (op < 8'h40) begin
      if (op[2:0] == 3'd4) return xild_pkg::IcB;
      if (op[2:0] == 3'd5) return xild_pkg::IcZ;
      return xild_pkg::IcNone;
    end
    if ((op >= 8'h70 && op <= 8'h7F) || (op >= 8'hB0 && op <= 8'hB7) ||
        (op >= 8'hE0 && op <= 8'hE7)) return xild_pkg::IcB;
    if (op >= 8'hB8 && op <= 8'hBF) return xild_pkg::IcV;
    if (op >= 8'hA0 && op <= 8'hA3) return xild_pkg::IcMoffs;
    case (op)
      8'h68: return xild_pkg::IcPush;
      8'h69, 8'h81, 8'hA9, 8'hC7: return xild_pkg::IcZ;
      8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1, 8'hC6, 8'hCD,
      8'hD4, 8'hD5, 8'hEB: return xild_pkg::IcB;
      8'hC2, 8'hCA: return xild_pkg::IcW;
      8'hC8: return xild_pkg::IcEnter;
      8'hE8, 8'hE9: return xild_pkg::IcRel;
      8'hF6, 8'hF7: return xild_pkg::IcGrp3;
      8'h9A, 8'hEA: return xild_pkg::IcFar;
      default: return xild_pkg::IcNone;
    endcase
  endfunction

  function automatic bit op2_modrm(logic [7:0] op);
    if ((op >= 8'h80 && op <= 8'h8F) || (op >= 8'hC8 && op <= 8'hCF)) return 1'b0;
    case (op)
      8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0B, 8'h0E, 8'h30, 8'h31, 8'h32,
      8'h33, 8'h34, 8'h35, 8'h37, 8'h77, 8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9,
      8'hAA: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic xild_pkg::imm_cls_e op2_imm(logic [7:0] op);
    if (op >= 8'h80 && op <= 8'h8F) return xild_pkg::IcRel;
    case (op)
      8'h70, 8'h71, 8'h72, 8'h73, 8'hA4, 8'hAC, 8'hBA, 8'hC2, 8'hC4, 8'hC5,
      8'hC6, 8'h0F: return xild_pkg::IcB;
      default: return xild_pkg::IcNone;
    endcase
  endfunction

  function automatic int imm_bytes(xild_pkg::imm_cls_e c, bit o16, bit w, bit lm,
                                   bit a16);
    case (c)
      xild_pkg::IcB:     return 1;
      xild_pkg::IcW:     return 2;
      xild_pkg::IcZ:     return (o16 && !w) ? 2 : 4;
      xild_pkg::IcPush:  return o16 ? 2 : 4;
      xild_pkg::IcV:     return w ? 8 : (o16 ? 2 : 4);
      xild_pkg::IcEnter: return 3;
      xild_pkg::IcRel:   return (o16 && !lm) ? 2 : 4;
      xild_pkg::IcMoffs: return lm ? (a16 ? 4 : 8) : (a16 ? 2 : 4);
      xild_pkg::IcFar:   return lm ? 0 : (o16 ? 4 : 6);
      default: return 0;
    endcase
  endfunction

  function automatic int ea_len(input logic [7:0] b[16], input int n, input int p,
                                input bit a16);
    logic [7:0] m;
    int len;
    len = 1;
    if (p >= n) return 1;
    m = b[p & 15];
    if (m[7:6] == 2'd3) return 1;
    if (a16) begin
      if (m[7:6] == 2'd0 && m[2:0] == 3'd6) len += 2;
      else if (m[7:6] == 2'd1) len += 1;
      else if (m[7:6] == 2'd2) len += 2;
      return len;
    end
    if (m[2:0] == 3'd4) begin
      len++;
      if (m[7:6] == 2'd0 && p + 1 < n && b[(p + 1) & 15][2:0] == 3'd5) len += 4;
    end else if (m[7:6] == 2'd0 && m[2:0] == 3'd5) begin
      len += 4;
    end
    if (m[7:6] == 2'd1) len += 1;
    else if (m[7:6] == 2'd2) len += 4;
    return len;
  endfunction

  function automatic int vex_imm(int map, logic [7:0] op);
    if (map == 3) return 1;
    if (map == 1 && ((op >= 8'h70 && op <= 8'h73) || op == 8'hC2 || op == 8'hC4 ||
                     op == 8'hC5 || op == 8'hC6)) return 1;
    return 0;
  endfunction

  function automatic void decode_insn(input logic [7:0] b[16], input int n, input bit lm,
                                      output int len, output xild_pkg::out_beat_t r);
    int p;
    int map;
    int rg;
    int il;
    bit o16;
    bit a16;
    bit w;
    bit a16m;
    logic [7:0] x;
    logic [7:0] op;
    logic [7:0] op2;
    logic [7:0] vop;
    logic [15:0] row;
    xild_pkg::imm_cls_e c;
    r = '0;
    len = 1;
    p = 0;
    o16 = 0;
    a16 = 0;
    w = 0;
    if (n <= 0) return;
    while (p < n) begin
      x = b[p & 15];
      if (x == xild_pkg::OpOsz) o16 = 1;
      else if (x == xild_pkg::OpAsz) a16 = 1;
      else if (!is_legacy(x)) break;
      p++;
    end
    a16m = !lm && a16;
    x = b[p & 15];
    if (p < n && (x == xild_pkg::OpVex2 || x == xild_pkg::OpVex3 ||
                  (lm && x == xild_pkg::OpEvex))) begin
      map = 1;
      if (x == xild_pkg::OpVex3) begin
        if (p + 1 < n) map = int'(b[(p + 1) & 15][4:0]);
        p += 3;
      end else if (x == xild_pkg::OpEvex) begin
        if (p + 1 < n) map = int'(b[(p + 1) & 15][2:0]);
        p += 4;
      end else begin
        p += 2;
      end
      if (p < n) begin
        vop = b[p & 15];
        p++;
        if (!(map == 1 && vop == 8'h77)) p += ea_len(b, n, p, a16m);
        p += vex_imm(map, vop);
      end
      len = p;
      return;
    end
    if (lm && p < n && b[p & 15][7:4] == 4'h4) begin
      w = b[p & 15][3];
      p++;
    end
    if (p >= n) begin
      len = (p != 0) ? p : 1;
      return;
    end
    op = b[p & 15];
    p++;
    if (op == xild_pkg::OpEsc) begin
      if (p >= n) begin
        len = p;
        return;
      end
      op2 = b[p & 15];
      p++;
      if (op2 == 8'h38 || op2 == 8'h3A) begin
        if (p < n) p++;
        p += ea_len(b, n, p, a16m);
        if (op2 == 8'h3A && p < n) p++;
        len = p;
        return;
      end
      if (op2 == 8'h05 || op2 == 8'h34) r.syscall_flag = 1'b1;
      else if (op2 == 8'h1F) r.nop_flag = 1'b1;
      if (op2_modrm(op2)) p += ea_len(b, n, p, a16m);
      p += imm_bytes(op2_imm(op2), o16, w, lm, a16);
      len = p;
      return;
    end
    rg = -1;
    if (op == 8'h90) r.nop_flag = 1'b1;
    else if (op == 8'hC3 || op == 8'hCB || op == 8'hC2 || op == 8'hCA) r.return_flag = 1'b1;
    row = modrm_row(op[7:4]);
    if (row[op[3:0]]) begin
      if (p < n) rg = int'(b[p & 15][5:3]);
      if (op == 8'hFF && (rg == 2 || rg == 4)) begin
        r.indirect_branch_flag = 1'b1;
        r.call_flag = (rg == 2);
      end
      p += ea_len(b, n, p, a16m);
    end
    c = op1_imm(op);
    if (c == xild_pkg::IcGrp3)
      c = (rg == 0 || rg == 1) ? ((op == 8'hF6) ? xild_pkg::IcB : xild_pkg::IcZ) :
          xild_pkg::IcNone;
    il = imm_bytes(c, o16, w, lm, a16);
    if ((op == 8'hE9 || op == 8'hE8) && p + il <= n) begin
      if (il >= 4)
        r.rel_offset = {b[(p + 3) & 15], b[(p + 2) & 15], b[(p + 1) & 15], b[p & 15]};
      else
        r.rel_offset = {{16{b[(p + 1) & 15][7]}}, b[(p + 1) & 15], b[p & 15]};
      if (op == 8'hE9) r.direct_jump_flag = 1'b1;
      else r.call_flag = 1'b1;
    end else if (op == 8'hEB && p < n) begin
      r.rel_offset = {{24{b[p & 15][7]}}, b[p & 15]};
      r.direct_jump_flag = 1'b1;
    end else if (op == 8'hCD && p < n && b[p & 15] == 8'h80) begin
      r.syscall_flag = 1'b1;
    end
    p += il;
    len = p;
  endfunction

  function automatic xild_pkg::out_beat_t predict_decode(xild_pkg::in_beat_t ib, bit lm);
    logic [7:0] b[16];
    int n;
    int len;
    xild_pkg::out_beat_t r;
    for (int i = 0; i < 8; i++) begin
      b[i] = ib.window_low[8*i +: 8];
      b[i + 8] = ib.window_high[8*i +: 8];
    end
    n = (ib.bytes_available > 5'd16) ? 16 : int'(ib.bytes_available);
    decode_insn(b, n, lm, len, r);
    r.insn_length = (len > 16) ? 5'd16 : 5'(len);
    r.too_long = (len > 15);
    return r;
  endfunction

  // bytes listed left to right, first byte in the top bits
  function automatic xild_pkg::in_beat_t mk(logic [127:0] s, int cnt);
    xild_pkg::in_beat_t ib;
    for (int i = 0; i < 8; i++) begin
      ib.window_low[8*i +: 8] = s[127 - 8*i -: 8];
      ib.window_high[8*i +: 8] = s[63 - 8*i -: 8];
    end
    ib.bytes_available = 5'(cnt);
    return ib;
  endfunction

  function automatic xild_pkg::out_beat_t res(int len, bit tl, bit [5:0] fl,
                                              logic [31:0] off);
    xild_pkg::out_beat_t r;
    r.insn_length = 5'(len);
    r.too_long = tl;
    {r.syscall_flag, r.direct_jump_flag, r.call_flag, r.indirect_branch_flag,
     r.return_flag, r.nop_flag} = fl;
    r.rel_offset = off;
    return r;
  endfunction

  function automatic void add_row(xild_pkg::in_beat_t ib, bit lm, bit fixed,
                                  xild_pkg::out_beat_t fx);
    window_row_t w;
    w.ib = ib;
    w.lm = lm;
    w.fixed = fixed;
    w.fx = fx;
    windows.push_back(w);
  endfunction

  function automatic xild_pkg::in_beat_t rand_window();
    logic [7:0] b[16];
    logic [7:0] pick;
    xild_pkg::in_beat_t ib;
    int k;
    int kind;
    logic [7:0] pfx[11];
    logic [7:0] spec[22];
    pfx = '{8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65};
    spec = '{8'hE8, 8'hE9, 8'hEB, 8'hFF, 8'hCD, 8'hC3, 8'hC2, 8'hCA, 8'hCB, 8'h90, 8'hC4,
             8'hC5, 8'h62, 8'h9A, 8'hEA, 8'hF6, 8'hF7, 8'hA0, 8'hA3, 8'hB8, 8'h68, 8'hC8};
    for (int i = 0; i < 16; i++) b[i] = 8'($urandom);
    k = 0;
    if ($urandom_range(9) != 0) begin
      repeat ($urandom_range(3)) begin
        b[k] = pfx[$urandom_range(10)];
        k++;
      end
      if ($urandom_range(3) == 0) begin
        b[k] = 8'h40 | 8'($urandom_range(15));
        k++;
      end
      kind = $urandom_range(9);
      if (kind < 3) begin
        k++;
      end else if (kind < 6) begin
        b[k] = xild_pkg::OpEsc;
        case ($urandom_range(7))
          0: b[k + 1] = 8'h05;
          1: b[k + 1] = 8'h34;
          2: b[k + 1] = 8'h1F;
          3: b[k + 1] = 8'h38;
          4: b[k + 1] = 8'h3A;
          5: b[k + 1] = 8'h80 | 8'($urandom_range(15));
          default: ;
        endcase
      end else begin
        pick = spec[$urandom_range(21)];
        b[k] = pick;
        if (pick == 8'hCD && $urandom_range(1)) b[k + 1] = 8'h80;
      end
    end
    for (int i = 0; i < 8; i++) begin
      ib.window_low[8*i +: 8] = b[i];
      ib.window_high[8*i +: 8] = b[i + 8];
    end
    ib.bytes_available = ($urandom_range(9) < 6) ? 5'd16 : 5'($urandom_range(16));
    return ib;
  endfunction

  task automatic apb_write(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrLongMode;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrLongMode;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[0] !== v[0]) begin
      mismatches++;
      if (mismatches <= 10) $display("long_mode readback: exp %0d got %0d", v[0], prdata[0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input bit lm);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    apb_write({31'd0, lm});
    apb_check({31'd0, lm});
    mode_r = lm;
  endtask

  task automatic send_window(input xild_pkg::in_beat_t ib, input bit fixed,
                             input xild_pkg::out_beat_t fx);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ib;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decoded_q.push_back(fixed ? fx : predict_decode(ib, mode_r));
  endtask

  always @(posedge clk_i) begin
    xild_pkg::out_beat_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data_o);
      end else begin
        e = decoded_q.pop_front();
        if (out_data_o.insn_length !== e.insn_length || out_data_o.too_long !== e.too_long ||
            out_data_o.syscall_flag !== e.syscall_flag ||
            out_data_o.direct_jump_flag !== e.direct_jump_flag ||
            out_data_o.call_flag !== e.call_flag ||
            out_data_o.indirect_branch_flag !== e.indirect_branch_flag ||
            out_data_o.return_flag !== e.return_flag || out_data_o.nop_flag !== e.nop_flag ||
            out_data_o.rel_offset !== e.rel_offset) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p got %p", e, out_data_o);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < rcv_idle);
  end

  initial begin
    xild_pkg::out_beat_t none;
    none = '0;
    cycles = 0;
    mismatches = 0;
    snd_idle = 17;
    rcv_idle = 59;
    mode_r = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    add_row(mk(128'h0, 0), 1, 1, res(1, 0, 6'b000000, 0));
    add_row(mk({8'h90, 120'h0}, 1), 1, 1, res(1, 0, 6'b000001, 0));
    add_row(mk({8'hC3, 120'h0}, 1), 1, 1, res(1, 0, 6'b000010, 0));
    add_row(mk({8'hEB, 8'h80, 112'h0}, 2), 1, 1, res(2, 0, 6'b010000, 32'hFFFFFF80));
    add_row(mk({8'hCD, 8'h80, 112'h0}, 2), 1, 1, res(2, 0, 6'b100000, 0));
    add_row(mk({8'h0F, 8'h05, 112'h0}, 2), 1, 1, res(2, 0, 6'b100000, 0));
    add_row(mk({128{1'b1}} & {16{8'hF0}}, 16), 1, 1, res(16, 1, 6'b000000, 0));
    add_row(mk({128{1'b1}}, 16), 1, 0, none);
    add_row(mk({8'hE9, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 88'h0}, 16), 1, 0, none);
    add_row(mk({8'hE8, 8'h00, 8'h00, 8'h00, 8'h80, 88'h0}, 3), 1, 0, none);
    add_row(mk({8'hFF, 8'hD0, 112'h0}, 2), 1, 0, none);
    add_row(mk({8'hFF, 8'h24, 8'h25, 104'h0}, 16), 1, 0, none);
    add_row(mk({8'hC2, 8'h10, 8'h00, 104'h0}, 3), 1, 0, none);
    add_row(mk({8'h0F, 8'h1F, 8'h84, 104'h0}, 16), 1, 0, none);
    add_row(mk({8'hC4, 8'hE3, 8'h79, 8'h0F, 8'hC1, 88'h0}, 16), 1, 0, none);
    add_row(mk({8'hC5, 8'hF8, 8'h77, 104'h0}, 16), 1, 0, none);
    add_row(mk({8'h62, 8'hF1, 8'h7C, 8'h48, 8'h10, 8'h80, 80'h0}, 16), 1, 0, none);
    add_row(mk({8'h0F, 8'h3A, 8'h0F, 8'hC1, 96'h0}, 3), 1, 0, none);
    add_row(mk({8'hF6, 8'h00, 8'h7F, 104'h0}, 16), 1, 0, none);
    add_row(mk({8'h48, 8'hB8, 112'h1122334455667788}, 16), 1, 0, none);
    add_row(mk({8'h66, 8'h9A, 112'h0}, 16), 0, 0, none);
    add_row(mk({8'hEA, 120'h0}, 16), 0, 0, none);
    add_row(mk({8'h66, 8'hE9, 8'h00, 8'h80, 96'h0}, 16), 0, 0, none);
    add_row(mk({8'h67, 8'h8B, 8'h06, 104'h0}, 16), 0, 0, none);
    add_row(mk({8'hC4, 8'hE2, 8'h79, 8'h18, 8'h04, 88'h0}, 16), 0, 0, none);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(1'b1);

    foreach (windows[i]) begin
      if (windows[i].lm != mode_r) set_mode(windows[i].lm);
      send_window(windows[i].ib, windows[i].fixed, windows[i].fx);
    end

    set_mode(1'b1);
    repeat (500) send_window(rand_window(), 0, none);
    snd_idle = 59;
    rcv_idle = 17;
    set_mode(1'b0);
    repeat (500) send_window(rand_window(), 0, none);
    snd_idle = 0;
    rcv_idle = 0;
    set_mode(1'b1);
    repeat (250) send_window(rand_window(), 0, none);
    set_mode(1'b0);
    repeat (250) send_window(rand_window(), 0, none);

    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/xild_pkg.sv
rtl/xild_addr.sv
rtl/xild_core.sv
rtl/x86_insn_length_decoder_unit.sv
verif/x86_insn_length_decoder_unit_tb.sv
